// ----- rtl/pap_bp_pkg.sv -----
// ----------------------------------------------------------------------------
// pap_bp_pkg
// Shared constants, codes and controller command type for the PAp predictor.
// ----------------------------------------------------------------------------
package pap_bp_pkg;

  localparam int SELECT_BITS  = 6;
  localparam int HISTORY_BITS = 12;
  localparam int NUM_SETS     = 1 << SELECT_BITS;
  localparam int SLOT_BITS    = SELECT_BITS + HISTORY_BITS;
  localparam int NUM_SLOTS    = 1 << SLOT_BITS;
  localparam int ADDR_W       = 64;

  localparam logic [1:0] CTR_MAX = 2'b11;
  localparam logic [1:0] CTR_MIN = 2'b00;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  typedef struct packed {
    logic                 clear;       // clearing pass write this cycle
    logic [SLOT_BITS-1:0] clear_addr;
    logic                 capture;     // latch item, read history
    logic                 ctr_read;    // read counter at {set, history}
    logic                 finish;      // write back or emit result
  } cmd_t;

endpackage

// ----- rtl/pap_bp_ctrl.sv -----
// ----------------------------------------------------------------------------
// pap_bp_ctrl
// Sequencer: clearing pass after reset, then three steps per item.
// ----------------------------------------------------------------------------
module pap_bp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output pap_bp_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HIST  = 2'd2;
  localparam logic [1:0] ST_CTR   = 2'd3;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [pap_bp_pkg::SLOT_BITS-1:0] clear_cnt;
  logic                            clear_last;

  assign clear_last = (clear_cnt == {pap_bp_pkg::SLOT_BITS{1'b1}});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_HIST;
      ST_HIST:  state_next = ST_CTR;
      ST_CTR:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_cnt <= clear_cnt + 1'b1;
    end
  end

  assign busy           = (state != ST_IDLE);
  assign cmd.clear      = (state == ST_CLEAR);
  assign cmd.clear_addr = clear_cnt;
  assign cmd.capture    = (state == ST_IDLE) && start;
  assign cmd.ctr_read   = (state == ST_HIST);
  assign cmd.finish     = (state == ST_CTR);

endmodule

// ----- rtl/pap_bp_datapath.sv -----
// ----------------------------------------------------------------------------
// pap_bp_datapath
// History and counter memories, item registers, counter update and result.
// ----------------------------------------------------------------------------
module pap_bp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pap_bp_pkg::cmd_t                     cmd,
  input  logic                                 kind,
  input  logic [pap_bp_pkg::SELECT_BITS-1:0]   branch_set,
  input  logic                                 is_direct,
  input  logic [pap_bp_pkg::ADDR_W-1:0]        branch_target,
  input  logic                                 was_taken,
  output logic                                 done,
  output logic                                 predict_taken,
  output logic [pap_bp_pkg::ADDR_W-1:0]        predict_target
);

  logic [pap_bp_pkg::HISTORY_BITS-1:0] hist_mem [pap_bp_pkg::NUM_SETS];
  logic [1:0]                          ctr_mem  [pap_bp_pkg::NUM_SLOTS];

  logic                                kind_r;
  logic [pap_bp_pkg::SELECT_BITS-1:0]  set_r;
  logic                                direct_r;
  logic [pap_bp_pkg::ADDR_W-1:0]       target_r;
  logic                                taken_r;
  logic [pap_bp_pkg::HISTORY_BITS-1:0] hist_rd;
  logic [1:0]                          ctr_rd;
  logic [pap_bp_pkg::ADDR_W-1:0]       ind_target;

  logic [pap_bp_pkg::SLOT_BITS-1:0]    slot;
  logic [1:0]                          ctr_next;
  logic [pap_bp_pkg::HISTORY_BITS:0]   hist_shift;
  logic                                do_update;

  assign slot       = {set_r, hist_rd};
  assign hist_shift = {hist_rd, taken_r};
  assign do_update  = cmd.finish && (kind_r == pap_bp_pkg::KIND_UPDATE);

  always_comb begin
    ctr_next = ctr_rd;
    if (taken_r) begin
      if (ctr_rd != pap_bp_pkg::CTR_MAX) ctr_next = ctr_rd + 2'd1;
    end else begin
      if (ctr_rd != pap_bp_pkg::CTR_MIN) ctr_next = ctr_rd - 2'd1;
    end
  end

  // item registers and history read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind;
      set_r    <= branch_set;
      direct_r <= is_direct;
      target_r <= branch_target;
      taken_r  <= was_taken;
      hist_rd  <= hist_mem[branch_set];
    end
  end

  // history write port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      hist_mem[cmd.clear_addr[pap_bp_pkg::SELECT_BITS-1:0]] <= '0;
    end else if (do_update) begin
      hist_mem[set_r] <= hist_shift[pap_bp_pkg::HISTORY_BITS-1:0];
    end
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (cmd.ctr_read) ctr_rd <= ctr_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      ctr_mem[cmd.clear_addr] <= pap_bp_pkg::CTR_MIN;
    end else if (do_update) begin
      ctr_mem[slot] <= ctr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ind_target <= '0;
    end else if (do_update && !direct_r) begin
      ind_target <= target_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish && (kind_r == pap_bp_pkg::KIND_PREDICT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      predict_taken  <= ctr_rd[1];
      predict_target <= direct_r ? target_r : ind_target;
    end
  end

endmodule

// ----- rtl/pap_two_level_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// pap_two_level_branch_predictor
// Per-address two-level adaptive predictor: private history per address set,
// private 2-bit counter table per set indexed by that history.
//
//   channel   handshake        fields
//   item in   start / busy     kind, branch_address, is_direct,
//                              branch_target, was_taken
//   result    done (1 cycle)   predict_taken, predict_target
//
// An item is taken when start is high and busy low; it then goes through
// history read, counter read and write back in that order, set by the two
// memory reads in series. A predict result shows on done in the cycle after
// the write back, while the next item may already be taken. Updates give no
// result. After reset a clearing pass writes every counter, with busy high.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module pap_two_level_branch_predictor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [pap_bp_pkg::ADDR_W-1:0] branch_address,
  input  logic                          is_direct,
  input  logic [pap_bp_pkg::ADDR_W-1:0] branch_target,
  input  logic                          was_taken,
  output logic                          done,
  output logic                          predict_taken,
  output logic [pap_bp_pkg::ADDR_W-1:0] predict_target
);

  pap_bp_pkg::cmd_t cmd;

  pap_bp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // address bits above the set select are not used
  pap_bp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .kind           (kind),
    .branch_set     (branch_address[pap_bp_pkg::SELECT_BITS-1:0]),
    .is_direct      (is_direct),
    .branch_target  (branch_target),
    .was_taken      (was_taken),
    .done           (done),
    .predict_taken  (predict_taken),
    .predict_target (predict_target)
  );

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PAp two-level branch predictor. A scoreboard
// keeps its own history registers, counter tables and indirect target, and
// works out the expected prediction for every predict transfer. A short
// directed run covers reset state, saturation and target selection. Random
// loop-like and biased branch streams train the counters, with noise mixed in.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         SELECT_BITS  = pap_bp_pkg::SELECT_BITS;
  localparam int         HISTORY_BITS = pap_bp_pkg::HISTORY_BITS;
  localparam int         NUM_SETS     = pap_bp_pkg::NUM_SETS;
  localparam int         SLOT_BITS    = pap_bp_pkg::SLOT_BITS;
  localparam int         NUM_SLOTS    = pap_bp_pkg::NUM_SLOTS;
  localparam int         ADDR_W       = pap_bp_pkg::ADDR_W;
  localparam logic [1:0] CTR_MAX      = pap_bp_pkg::CTR_MAX;
  localparam logic [1:0] CTR_MIN      = pap_bp_pkg::CTR_MIN;
  localparam logic       KIND_PREDICT = pap_bp_pkg::KIND_PREDICT;
  localparam logic       KIND_UPDATE  = pap_bp_pkg::KIND_UPDATE;

  localparam int ITEM_TARGET = 2000;
  // clearing pass plus items, several times over
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic              taken;
    logic [ADDR_W-1:0] target;
  } prediction_t;

  class pap_scoreboard;
    logic [HISTORY_BITS-1:0] hist_regs [NUM_SETS];
    logic [1:0]              ctrs [NUM_SLOTS];
    logic [ADDR_W-1:0]       last_ind_target;
    prediction_t             pending_q [$];
    int                      mismatches;
    int                      checked;

    function new();
      foreach (hist_regs[i]) hist_regs[i] = '0;
      foreach (ctrs[i]) ctrs[i] = CTR_MIN;
      last_ind_target = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // apply one accepted transfer to the shadow state
    function void note_item(logic k, logic [ADDR_W-1:0] a, logic d,
                            logic [ADDR_W-1:0] t, logic w);
      logic [SELECT_BITS-1:0] set;
      logic [SLOT_BITS-1:0]   slot;
      logic [1:0]             ctr;
      prediction_t            p;
      set  = a[SELECT_BITS-1:0];
      slot = {set, hist_regs[set]};
      ctr  = ctrs[slot];
      if (k == KIND_PREDICT) begin
        p.taken  = ctr[1];
        p.target = d ? t : last_ind_target;
        pending_q = {pending_q, p};
      end else begin
        if (!d) last_ind_target = t;
        if (w) begin
          if (ctr != CTR_MAX) ctr = ctr + 2'd1;
        end else begin
          if (ctr != CTR_MIN) ctr = ctr - 2'd1;
        end
        ctrs[slot] = ctr;
        hist_regs[set] = {hist_regs[set][HISTORY_BITS-2:0], w};
      end
    endfunction

    function void check_result(logic taken, logic [ADDR_W-1:0] target);
      prediction_t p;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got taken=%0b target=%h",
                 $time, taken, target);
        mismatches++;
        return;
      end
      p = pending_q.pop_front();
      checked++;
      if (taken !== p.taken) begin
        $display("%0t: predict_taken mismatch: expected %0b, got %0b",
                 $time, p.taken, taken);
        mismatches++;
      end
      if (target !== p.target) begin
        $display("%0t: predict_target mismatch: expected %h, got %h",
                 $time, p.target, target);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              kind;
  logic [ADDR_W-1:0] branch_address;
  logic              is_direct;
  logic [ADDR_W-1:0] branch_target;
  logic              was_taken;
  logic              done;
  logic              predict_taken;
  logic [ADDR_W-1:0] predict_target;

  pap_scoreboard sb;
  logic          start_drv;   // value start will hold after this step
  int            idle_pct;
  int            items_sent;
  int            cycle_count;

  pap_two_level_branch_predictor dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .branch_address (branch_address),
    .is_direct      (is_direct),
    .branch_target  (branch_target),
    .was_taken      (was_taken),
    .done           (done),
    .predict_taken  (predict_taken),
    .predict_target (predict_target)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions outstanding",
               cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(predict_taken, predict_target);
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic k, input logic [ADDR_W-1:0] a, input logic d,
                           input logic [ADDR_W-1:0] t, input logic w);
    int gap;
    kind           <= k;
    branch_address <= a;
    is_direct      <= d;
    branch_target  <= t;
    was_taken      <= w;
    start          <= 1'b1;
    start_drv      = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(k, a, d, t, w);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start     <= 1'b0;
      start_drv = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    if (start_drv) begin
      start     <= 1'b0;
      start_drv = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]      a;
    logic [ADDR_W-1:0]      t;
    logic [SELECT_BITS-1:0] set;
    logic [7:0]             pattern;
    logic                   d;
    logic                   w;
    int                     period;
    int                     len;
    int                     mode;
    int                     bias;
    int                     phase;

    sb          = new();
    cycle_count = 0;
    items_sent  = 0;
    idle_pct    = 21;
    start_drv   = 1'b0;
    rst            <= 1'b1;
    start          <= 1'b0;
    kind           <= KIND_PREDICT;
    branch_address <= '0;
    is_direct      <= 1'b0;
    branch_target  <= '0;
    was_taken      <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset state: not taken, indirect target zero; was_taken ignored
    send_item(KIND_PREDICT, '0, 1'b0, rand64(), 1'b1);
    send_item(KIND_PREDICT, '1, 1'b1, '1, 1'b0);
    // not-taken update at zero saturates, indirect target recorded
    send_item(KIND_UPDATE, '0, 1'b0, '1, 1'b0);
    send_item(KIND_PREDICT, '0, 1'b0, '0, 1'b0);
    // direct update leaves the indirect target alone
    send_item(KIND_UPDATE, 64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555, 1'b1);
    send_item(KIND_PREDICT, 64'h0000_0000_0000_0011, 1'b0, '0, 1'b0);
    // set 63 with changing upper bits: history fills with ones, counter saturates
    for (int i = 0; i < 16; i++) begin
      a = rand64();
      a[SELECT_BITS-1:0] = '1;
      send_item(KIND_UPDATE, a, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    end
    send_item(KIND_PREDICT, '1, 1'b1, 64'h8000_0000_0000_0001, 1'b0);
    send_item(KIND_UPDATE, '1, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_item(KIND_PREDICT, 64'hFFFF_0000_FFFF_003F, 1'b0, '1, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
        wait_results_drained();
        idle_pct = 68;
        phase = 1;
      end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        wait_results_drained();
        idle_pct = 0;
        phase = 2;
      end
      mode = $urandom_range(99);
      set  = SELECT_BITS'($urandom);
      d    = 1'($urandom);
      t    = rand64();
      if (mode < 60) begin
        // loop-like branch: periodic outcome, predict before each resolve
        period  = $urandom_range(1, 6);
        pattern = 8'($urandom);
        len     = $urandom_range(8, 30);
        for (int i = 0; i < len; i++) begin
          w = pattern[i % period];
          a = rand64();
          a[SELECT_BITS-1:0] = set;
          send_item(KIND_PREDICT, a, d, t, 1'($urandom));
          a = rand64();
          a[SELECT_BITS-1:0] = set;
          if ($urandom_range(9) == 0) t = rand64();
          send_item(KIND_UPDATE, a, d, t, w);
        end
      end else if (mode < 80) begin
        // strongly biased branch
        bias = $urandom_range(1) ? 90 : 10;
        len  = $urandom_range(8, 30);
        for (int i = 0; i < len; i++) begin
          a = rand64();
          a[SELECT_BITS-1:0] = set;
          send_item(KIND_PREDICT, a, d, t, 1'($urandom));
          a = rand64();
          a[SELECT_BITS-1:0] = set;
          send_item(KIND_UPDATE, a, d, t, $urandom_range(99) < bias);
        end
      end else begin
        send_item(1'($urandom), rand64(), d, t, 1'($urandom));
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d transfers over three idle profiles; %0d predictions checked.",
             items_sent, sb.checked);
    $display("%0d mismatches, %0d predictions left unanswered.",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pap_bp_pkg.sv
rtl/pap_bp_ctrl.sv
rtl/pap_bp_datapath.sv
rtl/pap_two_level_branch_predictor.sv
sim/tb_top.sv
